// ===== src/skst_pkg.sv =====
package skst_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int SCORE_W  = 16;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 3;
    localparam int COUNT_W  = 4;

    localparam int S_FIELDS_W = MODE_W + KEY_W + SCORE_W + INDEX_W;
    localparam int M_FIELDS_W = STATUS_W + POS_W + KEY_W + SCORE_W + COUNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } skst_entry_t;

    typedef struct packed {
        logic               capture;
        logic [KEY_W-1:0]   cmp_key;
        logic [SCORE_W-1:0] cmp_score;
        logic               write;
        logic               del_en;
        logic               ins_en;
        skst_entry_t        new_entry;
    } skst_ctl_t;

endpackage

// ===== src/sorted_keyed_score_table_unit.sv =====
// Sorted table of up to TABLE_DEPTH unique 32-bit keys with signed 16-bit scores, kept in
// descending score order with ties in arrival order. Each entry lives in one cell of a chain;
// on the accept edge every cell compares its key and score with the incoming beat; then, once
// the output register is free, all cells shift toward or away from their neighbors at once and
// the result is loaded into the output register in the same cycle. A new beat is taken only
// once the previous result is loaded, which waits while m_tready low holds a result there.
// The table needs no clearing after reset; the entry count starts at zero.
module sorted_keyed_score_table_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[1:0], key[33:2], score[49:34], index[52:50]
    input  logic [skst_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], position[5:3], key_out[37:6], score_out[53:38], entry_count[57:54]
    output logic [skst_pkg::M_TDATA_W-1:0]  m_tdata
);
    import skst_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic [MODE_W-1:0]    op_mode_reg;
    logic [KEY_W-1:0]     op_key_reg;
    logic [SCORE_W-1:0]   op_score_reg;
    logic [INDEX_W-1:0]   op_index_reg;

    logic [MODE_W-1:0]    in_mode;
    logic [KEY_W-1:0]     in_key;
    logic [SCORE_W-1:0]   in_score;
    logic [INDEX_W-1:0]   in_index;

    skst_ctl_t            ctl;
    skst_entry_t          e_v [TABLE_DEPTH];
    skst_entry_t          r_v [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_v;
    logic [TABLE_DEPTH-1:0] ge_v;
    logic [TABLE_DEPTH-1:0] match_v;
    logic [TABLE_DEPTH-1:0] below_v;
    logic [TABLE_DEPTH-1:0] lt_v;
    logic [TABLE_DEPTH-1:0] at_v;

    logic                 s_beat;
    logic                 out_free;
    logic                 found;
    logic                 op_ok;
    logic                 del_en;
    logic                 ins_en;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     position;
    logic [POS_W-1:0]     p_pos;
    logic [POS_W-1:0]     q_pos;
    skst_entry_t          rd_ent;
    skst_entry_t          out_ent;

    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_key   = s_tdata[MODE_W +: KEY_W];
    assign in_score = s_tdata[MODE_W+KEY_W +: SCORE_W];
    assign in_index = s_tdata[MODE_W+KEY_W+SCORE_W +: INDEX_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            assign valid_v[gi] = (count_reg > CNT_W'(gi));
            if (gi == 0) begin : g_first
                if (TABLE_DEPTH == 1) begin : g_only
                    skst_cell u_cell (
                        .aclk(aclk), .ctl(ctl), .valid(valid_v[gi]),
                        .prev_r(e_v[gi]), .prev_below(1'b1), .prev_lt(1'b1),
                        .next_e(e_v[gi]), .next_ge(1'b0),
                        .e_out(e_v[gi]), .r_out(r_v[gi]), .ge_out(ge_v[gi]),
                        .match_out(match_v[gi]), .below_out(below_v[gi]),
                        .lt_out(lt_v[gi]), .at_out(at_v[gi])
                    );
                end else begin : g_head
                    skst_cell u_cell (
                        .aclk(aclk), .ctl(ctl), .valid(valid_v[gi]),
                        .prev_r(e_v[gi]), .prev_below(1'b1), .prev_lt(1'b1),
                        .next_e(e_v[gi+1]), .next_ge(ge_v[gi+1]),
                        .e_out(e_v[gi]), .r_out(r_v[gi]), .ge_out(ge_v[gi]),
                        .match_out(match_v[gi]), .below_out(below_v[gi]),
                        .lt_out(lt_v[gi]), .at_out(at_v[gi])
                    );
                end
            end else if (gi == TABLE_DEPTH - 1) begin : g_last
                skst_cell u_cell (
                    .aclk(aclk), .ctl(ctl), .valid(valid_v[gi]),
                    .prev_r(r_v[gi-1]), .prev_below(below_v[gi-1]), .prev_lt(lt_v[gi-1]),
                    .next_e(e_v[gi]), .next_ge(1'b0),
                    .e_out(e_v[gi]), .r_out(r_v[gi]), .ge_out(ge_v[gi]),
                    .match_out(match_v[gi]), .below_out(below_v[gi]),
                    .lt_out(lt_v[gi]), .at_out(at_v[gi])
                );
            end else begin : g_mid
                skst_cell u_cell (
                    .aclk(aclk), .ctl(ctl), .valid(valid_v[gi]),
                    .prev_r(r_v[gi-1]), .prev_below(below_v[gi-1]), .prev_lt(lt_v[gi-1]),
                    .next_e(e_v[gi+1]), .next_ge(ge_v[gi+1]),
                    .e_out(e_v[gi]), .r_out(r_v[gi]), .ge_out(ge_v[gi]),
                    .match_out(match_v[gi]), .below_out(below_v[gi]),
                    .lt_out(lt_v[gi]), .at_out(at_v[gi])
                );
            end
        end
    endgenerate

    // position encoders and read select
    always_comb begin
        p_pos  = '0;
        q_pos  = '0;
        rd_ent = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (match_v[i]) begin
                p_pos = p_pos | POS_W'(i);
            end
            if (at_v[i]) begin
                q_pos = q_pos | POS_W'(i);
            end
            if (int'(op_index_reg) == i) begin
                rd_ent = e_v[i];
            end
        end
    end

    assign found = |match_v;

    always_comb begin
        status     = STATUS_OK;
        position   = '0;
        out_ent    = '0;
        count_next = count_reg;
        del_en     = 1'b0;
        ins_en     = 1'b0;
        case (op_mode_reg)
            MODE_INSERT: begin
                if (int'(count_reg) >= TABLE_DEPTH) begin
                    status = STATUS_FULL;
                end else if (found) begin
                    status = STATUS_DUP;
                end else begin
                    ins_en     = 1'b1;
                    position   = q_pos;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_DELETE, MODE_UPDATE: begin
                if (count_reg == '0) begin
                    status = STATUS_EMPTY;
                end else if (!found) begin
                    status = STATUS_MISSING;
                end else if (op_mode_reg == MODE_DELETE) begin
                    del_en     = 1'b1;
                    position   = p_pos;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    del_en     = 1'b1;
                    ins_en     = 1'b1;
                    position   = q_pos;
                end
            end
            MODE_READ: begin
                if (int'(op_index_reg) >= int'(count_reg) || int'(op_index_reg) >= TABLE_DEPTH)
                begin
                    status = STATUS_RANGE;
                end else begin
                    position = op_index_reg;
                    out_ent  = rd_ent;
                end
            end
            default: begin
                status = STATUS_OK;
            end
        endcase
    end

    assign op_ok = (status == STATUS_OK) && (op_mode_reg != MODE_READ);

    assign ctl.capture   = s_beat;
    assign ctl.cmp_key   = in_key;
    assign ctl.cmp_score = (in_mode == MODE_UPDATE || in_mode == MODE_INSERT) ? in_score : '0;
    assign ctl.write     = (state_reg == ST_APPLY) && out_free && op_ok;
    assign ctl.del_en    = del_en;
    assign ctl.ins_en    = ins_en;
    assign ctl.new_entry = '{key: op_key_reg, score: op_score_reg};

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                                     COUNT_W'(op_ok ? count_next : count_reg),
                                     out_ent.score, out_ent.key, position, status};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (ctl.write) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_beat) begin
            op_mode_reg  <= in_mode;
            op_key_reg   <= in_key;
            op_score_reg <= in_score;
            op_index_reg <= in_index;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // keys are unique, so at most one cell can match
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $onehot0(match_v))
        else $error("more than one cell matched the key");

    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= TABLE_DEPTH)
        else $error("entry count beyond table depth");

    // a table change always goes with a result beat loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.write |=> m_tvalid)
        else $error("table written without a result beat");

    // the insertion point is unique whenever an insert is applied
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.write && ctl.ins_en |-> $onehot(at_v))
        else $error("insert point not unique");

endmodule

// ===== src/skst_cell.sv =====
module skst_cell (
    input  logic                 aclk,
    input  skst_pkg::skst_ctl_t  ctl,
    input  logic                 valid,
    input  skst_pkg::skst_entry_t prev_r,
    input  logic                 prev_below,
    input  logic                 prev_lt,
    input  skst_pkg::skst_entry_t next_e,
    input  logic                 next_ge,
    output skst_pkg::skst_entry_t e_out,
    output skst_pkg::skst_entry_t r_out,
    output logic                 ge_out,
    output logic                 match_out,
    output logic                 below_out,
    output logic                 lt_out,
    output logic                 at_out
);
    import skst_pkg::*;

    skst_entry_t ent_reg;
    skst_entry_t ent_next;
    logic        match_reg;
    logic        ge_reg;
    logic        below;
    logic        rge;
    skst_entry_t r_ent;

    // removal view: entries before the removed one keep place, the rest move up
    assign below = prev_below && !(ctl.del_en && match_reg);
    assign r_ent = below ? ent_reg : next_e;
    assign rge   = below ? ge_reg : next_ge;

    // insertion view on top of the removal view
    assign lt_out = !ctl.ins_en || rge;
    assign at_out = ctl.ins_en && !rge && prev_lt;

    always_comb begin
        if (lt_out) begin
            ent_next = r_ent;
        end else if (at_out) begin
            ent_next = ctl.new_entry;
        end else begin
            ent_next = prev_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.write) begin
            ent_reg <= ent_next;
        end
        if (ctl.capture) begin
            match_reg <= valid && (ent_reg.key == ctl.cmp_key);
            ge_reg    <= valid && ($signed(ent_reg.score) >= $signed(ctl.cmp_score));
        end
    end

    assign e_out     = ent_reg;
    assign r_out     = r_ent;
    assign ge_out    = ge_reg;
    assign match_out = match_reg;
    assign below_out = below;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import skst_pkg::*;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
    } table_op_t;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic [POS_W-1:0]          position;
        logic [KEY_W-1:0]          key_out;
        logic signed [SCORE_W-1:0] score_out;
        logic [COUNT_W-1:0]        entry_count;
    } table_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    sorted_keyed_score_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow copy of the table
    logic [KEY_W-1:0]          tbl_key   [TABLE_DEPTH];
    logic signed [SCORE_W-1:0] tbl_score [TABLE_DEPTH];
    int                        tbl_count = 0;
    int                        peak_count = 0;
    int                        status_seen [6] = '{default: 0};

    table_op_t     pending_ops[$];
    table_result_t expected_results[$];
    logic [KEY_W-1:0] key_pool [12];

    int ops_total = 0;
    int ops_accepted = 0;
    int results_checked = 0;
    int fail_count = 0;
    bit beat_taken = 0;

    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic int place_entry(logic [KEY_W-1:0] k, logic signed [SCORE_W-1:0] s);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_score[pos] >= s) pos++;
        for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i]   = tbl_key[i-1];
            tbl_score[i] = tbl_score[i-1];
        end
        tbl_key[pos]   = k;
        tbl_score[pos] = s;
        tbl_count++;
        return pos;
    endfunction

    function automatic void remove_entry(int p);
        for (int i = p; i + 1 < tbl_count; i++) begin
            tbl_key[i]   = tbl_key[i+1];
            tbl_score[i] = tbl_score[i+1];
        end
        tbl_count--;
    endfunction

    function automatic table_result_t score_table_predict(table_op_t op);
        table_result_t r;
        int p;
        int pos;
        r.status    = STATUS_OK;
        r.key_out   = '0;
        r.score_out = '0;
        pos = 0;
        case (op.mode)
            MODE_INSERT: begin
                if (tbl_count >= TABLE_DEPTH) r.status = STATUS_FULL;
                else if (find_key(op.key) >= 0) r.status = STATUS_DUP;
                else pos = place_entry(op.key, op.score);
            end
            MODE_DELETE, MODE_UPDATE: begin
                if (tbl_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    p = find_key(op.key);
                    if (p < 0) begin
                        r.status = STATUS_MISSING;
                    end else begin
                        remove_entry(p);
                        if (op.mode == MODE_DELETE) pos = p;
                        else pos = place_entry(op.key, op.score);
                    end
                end
            end
            default: begin
                if (int'(op.index) >= tbl_count) begin
                    r.status = STATUS_RANGE;
                end else begin
                    pos         = int'(op.index);
                    r.key_out   = tbl_key[op.index];
                    r.score_out = tbl_score[op.index];
                end
            end
        endcase
        r.position    = pos[POS_W-1:0];
        r.entry_count = tbl_count[COUNT_W-1:0];
        status_seen[r.status]++;
        if (tbl_count > peak_count) peak_count = tbl_count;
        return r;
    endfunction

    task automatic add_op(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                          logic [SCORE_W-1:0] s, logic [INDEX_W-1:0] idx);
        table_op_t op;
        op.mode  = m;
        op.key   = k;
        op.score = s;
        op.index = idx;
        pending_ops.push_back(op);
        ops_total++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return key_pool[$urandom_range(0, 11)];
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3, 4: return SCORE_W'($urandom_range(0, 3)) - 16'd1;
            default: return r[SCORE_W-1:0];
        endcase
    endfunction

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin : driver
        table_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !beat_taken) begin
            s_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
            op = pending_ops.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {3'b000, op.index, op.score, op.key, op.mode};
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 25);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end else begin
            s_tvalid <= 1'b0;
        end
        beat_taken = 0;
    end

    // receiver: runs of ready, stall and coin-flip
    int rdy_kind = 0;
    int rdy_left = 0;
    always @(negedge aclk) begin : sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rdy_left == 0) begin
                rdy_kind = $urandom_range(0, 3);
                case (rdy_kind)
                    0: rdy_left = $urandom_range(1, 40);
                    1: rdy_left = $urandom_range(1, 8);
                    2: rdy_left = $urandom_range(10, 30);
                    default: rdy_left = $urandom_range(15, 30);
                endcase
            end
            rdy_left--;
            case (rdy_kind)
                0: m_tready <= 1'b1;
                1, 3: m_tready <= 1'b0;
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        table_op_t     op;
        table_result_t want;
        table_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                op.mode  = s_tdata[1:0];
                op.key   = s_tdata[33:2];
                op.score = s_tdata[49:34];
                op.index = s_tdata[52:50];
                expected_results.push_back(score_table_predict(op));
                ops_accepted++;
                beat_taken = 1;
            end
            if (m_tvalid && m_tready) begin
                got.status      = m_tdata[2:0];
                got.position    = m_tdata[5:3];
                got.key_out     = m_tdata[37:6];
                got.score_out   = m_tdata[53:38];
                got.entry_count = m_tdata[57:54];
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.position != want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, got.position);
                        fail_count++;
                    end
                    if (got.key_out != want.key_out) begin
                        $error("key_out: expected %h, got %h", want.key_out, got.key_out);
                        fail_count++;
                    end
                    if (got.score_out != want.score_out) begin
                        $error("score_out: expected %0d, got %0d",
                               want.score_out, got.score_out);
                        fail_count++;
                    end
                    if (got.entry_count != want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int ins_pct;
        int del_pct;
        int upd_pct;
        int r;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;
        for (int i = 4; i < 12; i++) key_pool[i] = $urandom;

        // empty table corners
        add_op(MODE_READ,   32'h0, 16'h0, 3'd0);
        add_op(MODE_DELETE, 32'h1, 16'h0, 3'd0);
        add_op(MODE_UPDATE, 32'h1, 16'h5, 3'd0);
        // fill with extremes and ties, a duplicate key and inserts past full, then read both ends
        add_op(MODE_INSERT, 32'h0000_0000, 16'h8000, 3'd0);
        add_op(MODE_INSERT, 32'hffff_ffff, 16'h7fff, 3'd0);
        add_op(MODE_INSERT, 32'h0000_0000, 16'h0001, 3'd0);
        add_op(MODE_INSERT, 32'h0000_0005, 16'h7fff, 3'd0);
        add_op(MODE_INSERT, 32'h0000_000a, 16'h0000, 3'd0);
        add_op(MODE_INSERT, 32'h0000_000b, 16'hffff, 3'd0);
        add_op(MODE_INSERT, 32'h0000_000c, 16'h0001, 3'd0);
        add_op(MODE_INSERT, 32'h0000_000d, 16'h0064, 3'd0);
        add_op(MODE_INSERT, 32'h8000_0000, 16'h8000, 3'd0);
        add_op(MODE_INSERT, 32'h0000_0014, 16'h0000, 3'd0);
        add_op(MODE_INSERT, 32'h0000_0005, 16'h0000, 3'd0);
        add_op(MODE_READ,   32'h0, 16'h0, 3'd7);
        add_op(MODE_READ,   32'h0, 16'h0, 3'd0);
        // update on a full table, then misses, deletes, an update and reads
        add_op(MODE_UPDATE, 32'h0000_0000, 16'h7fff, 3'd0);
        add_op(MODE_READ,   32'h0, 16'h0, 3'd2);
        add_op(MODE_DELETE, 32'h0000_0063, 16'h0, 3'd0);
        add_op(MODE_UPDATE, 32'h0000_0063, 16'h0, 3'd0);
        add_op(MODE_DELETE, 32'hffff_ffff, 16'h0, 3'd0);
        add_op(MODE_READ,   32'h0, 16'h0, 3'd7);
        add_op(MODE_DELETE, 32'h8000_0000, 16'h0, 3'd0);
        add_op(MODE_UPDATE, 32'h0000_000d, 16'h8000, 3'd0);
        add_op(MODE_READ,   32'h0, 16'h0, 3'd5);

        // random phases biased to fill, drain or churn the table
        for (int phase = 0; phase < 25; phase++) begin
            case ($urandom_range(0, 2))
                0: begin ins_pct = 60; del_pct = 10; upd_pct = 15; end
                1: begin ins_pct = 15; del_pct = 50; upd_pct = 15; end
                default: begin ins_pct = 30; del_pct = 20; upd_pct = 30; end
            endcase
            for (int n = 0; n < 60; n++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    add_op(MODE_INSERT, pick_key(), pick_score(),
                           INDEX_W'($urandom_range(0, 7)));
                else if (r < ins_pct + del_pct)
                    add_op(MODE_DELETE, pick_key(), pick_score(),
                           INDEX_W'($urandom_range(0, 7)));
                else if (r < ins_pct + del_pct + upd_pct)
                    add_op(MODE_UPDATE, pick_key(), pick_score(),
                           INDEX_W'($urandom_range(0, 7)));
                else
                    add_op(MODE_READ, pick_key(), pick_score(),
                           INDEX_W'($urandom_range(0, 7)));
            end
        end

        while (ops_accepted < ops_total) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d table operations checked, table depth peaked at %0d", results_checked,
                 peak_count);
        $display("outcomes: ok %0d, full %0d, duplicate %0d, empty %0d, missing %0d, range %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
